// ----- hdl/psa_pkg.sv -----
// Package for the packed SIMD ALU: operation codes and lane constants.
// Has no dependencies; used by psa_alu and packed_simd_alu_128.
`timescale 1ns / 1ps
`default_nettype none

package psa_pkg;

    localparam int unsigned ACT_W     = 6;
    localparam int unsigned REG_IDX_W = 5;
    localparam int unsigned NUM_REGS  = 32;
    localparam int unsigned VEC_W     = 128;
    localparam int unsigned HALF_W    = 64;

    typedef logic [ACT_W-1:0]     act_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;
    typedef logic [VEC_W-1:0]     vec_t;

    localparam act_t ACT_ADDW  = 6'd0;
    localparam act_t ACT_ADDH  = 6'd1;
    localparam act_t ACT_ADDB  = 6'd2;
    localparam act_t ACT_SUBW  = 6'd3;
    localparam act_t ACT_SUBH  = 6'd4;
    localparam act_t ACT_SUBB  = 6'd5;
    localparam act_t ACT_ADDSW = 6'd6;
    localparam act_t ACT_ADDSH = 6'd7;
    localparam act_t ACT_ADDSB = 6'd8;
    localparam act_t ACT_SUBSW = 6'd9;
    localparam act_t ACT_SUBSH = 6'd10;
    localparam act_t ACT_SUBSB = 6'd11;
    localparam act_t ACT_ADDUW = 6'd12;
    localparam act_t ACT_ADDUH = 6'd13;
    localparam act_t ACT_ADDUB = 6'd14;
    localparam act_t ACT_SUBUW = 6'd15;
    localparam act_t ACT_SUBUH = 6'd16;
    localparam act_t ACT_SUBUB = 6'd17;
    localparam act_t ACT_CGTW  = 6'd18;
    localparam act_t ACT_CGTH  = 6'd19;
    localparam act_t ACT_CGTB  = 6'd20;
    localparam act_t ACT_CEQW  = 6'd21;
    localparam act_t ACT_CEQH  = 6'd22;
    localparam act_t ACT_CEQB  = 6'd23;
    localparam act_t ACT_MAXW  = 6'd24;
    localparam act_t ACT_MAXH  = 6'd25;
    localparam act_t ACT_MINW  = 6'd26;
    localparam act_t ACT_MINH  = 6'd27;
    localparam act_t ACT_AND   = 6'd28;
    localparam act_t ACT_OR    = 6'd29;
    localparam act_t ACT_XOR   = 6'd30;
    localparam act_t ACT_NOR   = 6'd31;
    localparam act_t ACT_ZIPLW = 6'd32;
    localparam act_t ACT_ZIPLH = 6'd33;
    localparam act_t ACT_ZIPLB = 6'd34;
    localparam act_t ACT_ZIPHW = 6'd35;
    localparam act_t ACT_ZIPHH = 6'd36;
    localparam act_t ACT_ZIPHB = 6'd37;
    localparam act_t ACT_PACKW = 6'd38;
    localparam act_t ACT_PACKH = 6'd39;
    localparam act_t ACT_PACKB = 6'd40;
    localparam act_t ACT_CPYLD = 6'd41;
    localparam act_t ACT_CPYUD = 6'd42;
    localparam act_t ACT_ABSW  = 6'd43;
    localparam act_t ACT_ABSH  = 6'd44;
    localparam act_t ACT_BCSTH = 6'd45;
    localparam act_t ACT_LOAD  = 6'd46;
    localparam act_t ACT_READ  = 6'd47;

endpackage

`default_nettype wire

// ----- hdl/packed_simd_alu_128.sv -----
// Top level of the 128-bit packed SIMD ALU: register file, forwarding and stream handshakes.
// Depends on psa_pkg and psa_alu.
`timescale 1ns / 1ps
`default_nettype none

// The block holds 32 registers of 128 bits and, when not stalled, takes one item per
// clock cycle. An item is accepted into the operand stage, where both source registers
// are read from the register file memory into registers at the same clock edge. While
// the item waits there the lane datapath computes the result, which is written back to
// the register file and loaded into the output register at the edge at which the item
// leaves the operand stage. Items may follow one another in every cycle while the input
// is not stalled: a result that the previous item writes at the very edge at which the
// next item reads its operands is forwarded straight from the datapath. Register 0 always
// reads as zero. After reset every register reads as zero through a valid bit per
// register, so no clearing pass is needed. The input stalls only when the output register
// is full and not being taken while an item waits in the operand stage.
module packed_simd_alu_128
(
    input  wire          clk,
    input  wire          rst_n,
    input  wire          s_axis_tvalid,
    output logic         s_axis_tready,
    // action[5:0], dest_reg[10:6], src_s_reg[15:11], src_t_reg[20:16],
    // load_low[84:21], load_high[148:85], zero pad[151:149]
    input  wire  [151:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  wire          m_axis_tready,
    // result_low[63:0], result_high[127:64], was_written[128], zero pad[135:129]
    output logic [135:0] m_axis_tdata
);

    // Incoming fields.
    psa_pkg::act_t     in_action;
    psa_pkg::reg_idx_t in_dest;
    psa_pkg::reg_idx_t in_src_s;
    psa_pkg::reg_idx_t in_src_t;

    assign in_action = s_axis_tdata[5:0];
    assign in_dest   = s_axis_tdata[10:6];
    assign in_src_s  = s_axis_tdata[15:11];
    assign in_src_t  = s_axis_tdata[20:16];

    // Register file storage and per-register valid bits (an unwritten register reads zero).
    psa_pkg::vec_t                 regfile [psa_pkg::NUM_REGS];
    logic [psa_pkg::NUM_REGS-1:0]  valid_reg;

    // Operand stage.
    logic              s1_valid_reg;
    psa_pkg::act_t     s1_action_reg;
    psa_pkg::reg_idx_t s1_dest_reg;
    psa_pkg::vec_t     s1_load_reg;
    psa_pkg::vec_t     rdata_s_reg;
    psa_pkg::vec_t     rdata_t_reg;
    logic              zero_s_reg;
    logic              zero_t_reg;
    logic              fwd_s_reg;
    logic              fwd_t_reg;
    psa_pkg::vec_t     fwd_data_reg;

    // Output register.
    logic              m_valid_reg;
    psa_pkg::vec_t     m_result_reg;
    logic              m_written_reg;

    psa_pkg::vec_t     op_s;
    psa_pkg::vec_t     op_t;
    psa_pkg::vec_t     alu_result;
    logic              s1_advance;
    logic              s1_wen;
    logic              s1_known;
    logic              accept;

    assign s1_advance    = s1_valid_reg && (!m_valid_reg || m_axis_tready);
    assign s_axis_tready = !s1_valid_reg || s1_advance;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Operations and loads write their destination; reads and unassigned codes do not.
    assign s1_known = (s1_action_reg <= psa_pkg::ACT_READ);
    assign s1_wen   = s1_advance && (s1_action_reg != psa_pkg::ACT_READ) && s1_known
                      && (s1_dest_reg != '0);

    // A forwarded value wins over the memory read; otherwise zero covers register 0
    // and registers not written since reset.
    assign op_s = fwd_s_reg ? fwd_data_reg : (zero_s_reg ? '0 : rdata_s_reg);
    assign op_t = fwd_t_reg ? fwd_data_reg : (zero_t_reg ? '0 : rdata_t_reg);

    psa_alu u_alu
    (
        .action   (s1_action_reg),
        .src_s    (op_s),
        .src_t    (op_t),
        .load_val (s1_load_reg),
        .result   (alu_result)
    );

    // Register file: one write port and two registered read ports.
    always_ff @(posedge clk)
    begin
        if (s1_wen)
            regfile[s1_dest_reg] <= alu_result;
        if (accept)
        begin
            rdata_s_reg <= regfile[in_src_s];
            rdata_t_reg <= regfile[in_src_t];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= '0;
        else if (s1_wen)
            valid_reg[s1_dest_reg] <= 1'b1;
    end

    // Operand stage control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (s_axis_tready)
            s1_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_action_reg <= in_action;
            s1_dest_reg   <= in_dest;
            s1_load_reg   <= {s_axis_tdata[148:85], s_axis_tdata[84:21]};
            zero_s_reg    <= (in_src_s == '0) || !valid_reg[in_src_s];
            zero_t_reg    <= (in_src_t == '0) || !valid_reg[in_src_t];
            fwd_s_reg     <= s1_wen && (s1_dest_reg == in_src_s);
            fwd_t_reg     <= s1_wen && (s1_dest_reg == in_src_t);
            fwd_data_reg  <= alu_result;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_valid_reg <= 1'b0;
        else if (s1_advance)
            m_valid_reg <= 1'b1;
        else if (m_axis_tready)
            m_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s1_advance)
        begin
            m_result_reg  <= alu_result;
            m_written_reg <= s1_wen;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {7'd0, m_written_reg, m_result_reg};

`ifndef NO_ASSERTIONS
    a_no_write_r0: assert property (@(posedge clk) disable iff (!rst_n)
        s1_wen |-> (s1_dest_reg != '0))
        else $error("write to register 0");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> (s1_valid_reg && m_valid_reg && !m_axis_tready))
        else $error("input stalled without a full pipeline");

    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !s1_advance) |=> s1_valid_reg)
        else $error("operand stage lost an item");

    a_valid_set: assert property (@(posedge clk) disable iff (!rst_n)
        s1_wen |=> valid_reg[$past(s1_dest_reg)])
        else $error("written register not marked valid");
`endif

endmodule

`default_nettype wire

// ----- hdl/psa_alu.sv -----
// Combinational packed lane datapath of the SIMD ALU.
// Depends on psa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module psa_alu
(
    input  wire psa_pkg::act_t action,
    input  wire psa_pkg::vec_t src_s,
    input  wire psa_pkg::vec_t src_t,
    input  wire psa_pkg::vec_t load_val,
    output psa_pkg::vec_t      result
);

    // Index 0 is word lanes, 1 halfword lanes, 2 byte lanes.
    psa_pkg::vec_t r_add  [3];
    psa_pkg::vec_t r_sub  [3];
    psa_pkg::vec_t r_adds [3];
    psa_pkg::vec_t r_subs [3];
    psa_pkg::vec_t r_addu [3];
    psa_pkg::vec_t r_subu [3];
    psa_pkg::vec_t r_cgt  [3];
    psa_pkg::vec_t r_ceq  [3];
    psa_pkg::vec_t r_max  [3];
    psa_pkg::vec_t r_min  [3];
    psa_pkg::vec_t r_abs  [3];
    psa_pkg::vec_t r_zipl [3];
    psa_pkg::vec_t r_ziph [3];
    psa_pkg::vec_t r_pack [3];

    for (genvar gw = 0; gw < 3; gw++) begin : g_width
        localparam int W = 32 >> gw;
        localparam int N = psa_pkg::VEC_W / W;

        psa_pkg::vec_t add_v, sub_v, adds_v, subs_v, addu_v, subu_v;
        psa_pkg::vec_t cgt_v, ceq_v, max_v, min_v, abs_v, zipl_v, ziph_v, pack_v;

        always_comb
        begin
            logic [W-1:0] a;
            logic [W-1:0] b;
            logic [W:0]   ss;
            logic [W:0]   sd;
            logic [W:0]   su;
            logic         gt;
            add_v  = '0;
            sub_v  = '0;
            adds_v = '0;
            subs_v = '0;
            addu_v = '0;
            subu_v = '0;
            cgt_v  = '0;
            ceq_v  = '0;
            max_v  = '0;
            min_v  = '0;
            abs_v  = '0;
            zipl_v = '0;
            ziph_v = '0;
            pack_v = '0;
            for (int i = 0; i < N; i++)
            begin
                a  = src_s[i*W +: W];
                b  = src_t[i*W +: W];
                ss = {a[W-1], a} + {b[W-1], b};
                sd = {a[W-1], a} - {b[W-1], b};
                su = {1'b0, a} + {1'b0, b};
                gt = $signed(a) > $signed(b);
                add_v[i*W +: W] = a + b;
                sub_v[i*W +: W] = a - b;
                // Signed overflow shows as the two top bits of the wide sum differing.
                adds_v[i*W +: W] = (ss[W] != ss[W-1]) ? {ss[W], {(W-1){~ss[W]}}} : ss[W-1:0];
                subs_v[i*W +: W] = (sd[W] != sd[W-1]) ? {sd[W], {(W-1){~sd[W]}}} : sd[W-1:0];
                addu_v[i*W +: W] = su[W] ? {W{1'b1}} : su[W-1:0];
                subu_v[i*W +: W] = (a > b) ? a - b : '0;
                cgt_v[i*W +: W]  = {W{gt}};
                ceq_v[i*W +: W]  = {W{a == b}};
                max_v[i*W +: W]  = gt ? a : b;
                min_v[i*W +: W]  = ($signed(a) < $signed(b)) ? a : b;
                if (!b[W-1])
                    abs_v[i*W +: W] = b;
                else if (b == {1'b1, {(W-1){1'b0}}})
                    abs_v[i*W +: W] = {1'b0, {(W-1){1'b1}}};
                else
                    abs_v[i*W +: W] = -b;
            end
            for (int i = 0; i < N/2; i++)
            begin
                zipl_v[(2*i)*W +: W]   = src_t[i*W +: W];
                zipl_v[(2*i+1)*W +: W] = src_s[i*W +: W];
                ziph_v[(2*i)*W +: W]   = src_t[(N/2+i)*W +: W];
                ziph_v[(2*i+1)*W +: W] = src_s[(N/2+i)*W +: W];
                pack_v[i*W +: W]       = src_t[(2*i)*W +: W];
                pack_v[(N/2+i)*W +: W] = src_s[(2*i)*W +: W];
            end
        end

        assign r_add[gw]  = add_v;
        assign r_sub[gw]  = sub_v;
        assign r_adds[gw] = adds_v;
        assign r_subs[gw] = subs_v;
        assign r_addu[gw] = addu_v;
        assign r_subu[gw] = subu_v;
        assign r_cgt[gw]  = cgt_v;
        assign r_ceq[gw]  = ceq_v;
        assign r_max[gw]  = max_v;
        assign r_min[gw]  = min_v;
        assign r_abs[gw]  = abs_v;
        assign r_zipl[gw] = zipl_v;
        assign r_ziph[gw] = ziph_v;
        assign r_pack[gw] = pack_v;
    end

    always_comb
    begin
        case (action)
            psa_pkg::ACT_ADDW:  result = r_add[0];
            psa_pkg::ACT_ADDH:  result = r_add[1];
            psa_pkg::ACT_ADDB:  result = r_add[2];
            psa_pkg::ACT_SUBW:  result = r_sub[0];
            psa_pkg::ACT_SUBH:  result = r_sub[1];
            psa_pkg::ACT_SUBB:  result = r_sub[2];
            psa_pkg::ACT_ADDSW: result = r_adds[0];
            psa_pkg::ACT_ADDSH: result = r_adds[1];
            psa_pkg::ACT_ADDSB: result = r_adds[2];
            psa_pkg::ACT_SUBSW: result = r_subs[0];
            psa_pkg::ACT_SUBSH: result = r_subs[1];
            psa_pkg::ACT_SUBSB: result = r_subs[2];
            psa_pkg::ACT_ADDUW: result = r_addu[0];
            psa_pkg::ACT_ADDUH: result = r_addu[1];
            psa_pkg::ACT_ADDUB: result = r_addu[2];
            psa_pkg::ACT_SUBUW: result = r_subu[0];
            psa_pkg::ACT_SUBUH: result = r_subu[1];
            psa_pkg::ACT_SUBUB: result = r_subu[2];
            psa_pkg::ACT_CGTW:  result = r_cgt[0];
            psa_pkg::ACT_CGTH:  result = r_cgt[1];
            psa_pkg::ACT_CGTB:  result = r_cgt[2];
            psa_pkg::ACT_CEQW:  result = r_ceq[0];
            psa_pkg::ACT_CEQH:  result = r_ceq[1];
            psa_pkg::ACT_CEQB:  result = r_ceq[2];
            psa_pkg::ACT_MAXW:  result = r_max[0];
            psa_pkg::ACT_MAXH:  result = r_max[1];
            psa_pkg::ACT_MINW:  result = r_min[0];
            psa_pkg::ACT_MINH:  result = r_min[1];
            psa_pkg::ACT_AND:   result = src_s & src_t;
            psa_pkg::ACT_OR:    result = src_s | src_t;
            psa_pkg::ACT_XOR:   result = src_s ^ src_t;
            psa_pkg::ACT_NOR:   result = ~(src_s | src_t);
            psa_pkg::ACT_ZIPLW: result = r_zipl[0];
            psa_pkg::ACT_ZIPLH: result = r_zipl[1];
            psa_pkg::ACT_ZIPLB: result = r_zipl[2];
            psa_pkg::ACT_ZIPHW: result = r_ziph[0];
            psa_pkg::ACT_ZIPHH: result = r_ziph[1];
            psa_pkg::ACT_ZIPHB: result = r_ziph[2];
            psa_pkg::ACT_PACKW: result = r_pack[0];
            psa_pkg::ACT_PACKH: result = r_pack[1];
            psa_pkg::ACT_PACKB: result = r_pack[2];
            psa_pkg::ACT_CPYLD: result = {src_s[63:0], src_t[63:0]};
            psa_pkg::ACT_CPYUD: result = {src_t[127:64], src_s[127:64]};
            psa_pkg::ACT_ABSW:  result = r_abs[0];
            psa_pkg::ACT_ABSH:  result = r_abs[1];
            psa_pkg::ACT_BCSTH: result = {{4{src_t[79:64]}}, {4{src_t[15:0]}}};
            psa_pkg::ACT_LOAD:  result = load_val;
            psa_pkg::ACT_READ:  result = src_s;
            default:            result = '0;
        endcase
    end

endmodule

`default_nettype wire

// ----- dv/tb_packed_simd_alu_128.sv -----
// Testbench for packed_simd_alu_128: directed and random items checked against a predictor.
// Depends on psa_pkg and the block under test.
`timescale 1ns / 1ps

module tb_packed_simd_alu_128;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [151:0] s_axis_tdata;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;

    // Shadow copy of the register file and the queue of expected result items.
    logic [127:0] shadow_regs [32];
    logic [128:0] result_queue [$];
    int           error_count;
    int           send_idle_pct;
    int           recv_stall_pct;

    packed_simd_alu_128 i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #6 clk = ~clk;

    function automatic logic [127:0] read_shadow(input logic [4:0] r);
        if (r == 5'd0)
        begin
            return '0;
        end
        return shadow_regs[r];
    endfunction

    function automatic longint lane_sext(input logic [31:0] x, input int w);
        longint v;
        v = x;
        if (x[w-1])
        begin
            v = v - (longint'(1) << w);
        end
        return v;
    endfunction

    // Works out one lane of the arithmetic, compare and max/min groups.
    function automatic logic [31:0] lane_calc(input int kind, input logic [31:0] a,
                                              input logic [31:0] b, input int w);
        longint sa, sb, smax, smin, r;
        longint ua, ub, m;
        sa   = lane_sext(a, w);
        sb   = lane_sext(b, w);
        smax = (longint'(1) << (w - 1)) - 1;
        smin = -smax - 1;
        m    = (longint'(1) << w) - 1;
        ua   = a;
        ub   = b;
        case (kind)
            0: r = (ua + ub) & m;
            1: r = (ua - ub) & m;
            2, 3:
            begin
                r = (kind == 2) ? sa + sb : sa - sb;
                if (r > smax) r = smax;
                if (r < smin) r = smin;
                r = r & m;
            end
            4: r = (ua + ub > m) ? m : ua + ub;
            5: r = (ua > ub) ? ua - ub : 0;
            6: r = (sa > sb) ? m : 0;
            7: r = (ua == ub) ? m : 0;
            8: r = (sa > sb) ? ua : ub;
            default: r = (sa < sb) ? ua : ub;
        endcase
        return r[31:0];
    endfunction

    function automatic logic [31:0] get_lane(input logic [127:0] v, input int i, input int w);
        return 32'((v >> (i * w)) & ((128'd1 << w) - 1));
    endfunction

    function automatic void put_lane(inout logic [127:0] v, input int i, input int w,
                                     input logic [31:0] x);
        logic [127:0] m;
        m = ((128'd1 << w) - 1) << (i * w);
        v = (v & ~m) | ((128'(x) << (i * w)) & m);
    endfunction

    // Predicts the result item of one input item and updates the shadow registers.
    function automatic logic [128:0] predict_simd(input logic [151:0] item);
        psa_pkg::act_t act;
        logic [4:0]   rd;
        logic [127:0] s, t, d;
        int           w, n, half, base, kind;
        longint       x, smax;
        act  = item[5:0];
        rd   = item[10:6];
        s    = read_shadow(item[15:11]);
        t    = read_shadow(item[20:16]);
        d    = '0;
        if (act > psa_pkg::ACT_READ)
        begin
            return '0;
        end
        if (act == psa_pkg::ACT_READ)
        begin
            return {1'b0, s};
        end
        if (act == psa_pkg::ACT_LOAD)
        begin
            d = {item[148:85], item[84:21]};
        end
        else if (act < psa_pkg::ACT_MAXW || act < psa_pkg::ACT_AND)
        begin
            if (act < psa_pkg::ACT_MAXW)
            begin
                kind = act / 3;
                w    = (act % 3 == 0) ? 32 : ((act % 3 == 1) ? 16 : 8);
            end
            else
            begin
                kind = (act < psa_pkg::ACT_MINW) ? 8 : 9;
                w    = act[0] ? 16 : 32;
            end
            n = 128 / w;
            for (int i = 0; i < n; i++)
            begin
                put_lane(d, i, w, lane_calc(kind, get_lane(s, i, w), get_lane(t, i, w), w));
            end
        end
        else if (act == psa_pkg::ACT_AND) d = s & t;
        else if (act == psa_pkg::ACT_OR)  d = s | t;
        else if (act == psa_pkg::ACT_XOR) d = s ^ t;
        else if (act == psa_pkg::ACT_NOR) d = ~(s | t);
        else if (act < psa_pkg::ACT_PACKW)
        begin
            w    = ((act - psa_pkg::ACT_ZIPLW) % 3 == 0) ? 32 :
                   (((act - psa_pkg::ACT_ZIPLW) % 3 == 1) ? 16 : 8);
            half = 64 / w;
            base = (act >= psa_pkg::ACT_ZIPHW) ? half : 0;
            for (int i = 0; i < half; i++)
            begin
                put_lane(d, 2 * i, w, get_lane(t, base + i, w));
                put_lane(d, 2 * i + 1, w, get_lane(s, base + i, w));
            end
        end
        else if (act < psa_pkg::ACT_CPYLD)
        begin
            w    = (act == psa_pkg::ACT_PACKW) ? 32 : ((act == psa_pkg::ACT_PACKH) ? 16 : 8);
            half = 64 / w;
            for (int i = 0; i < half; i++)
            begin
                put_lane(d, i, w, get_lane(t, 2 * i, w));
                put_lane(d, half + i, w, get_lane(s, 2 * i, w));
            end
        end
        else if (act == psa_pkg::ACT_CPYLD) d = {s[63:0], t[63:0]};
        else if (act == psa_pkg::ACT_CPYUD) d = {t[127:64], s[127:64]};
        else if (act < psa_pkg::ACT_BCSTH)
        begin
            w    = (act == psa_pkg::ACT_ABSW) ? 32 : 16;
            smax = (longint'(1) << (w - 1)) - 1;
            for (int i = 0; i < 128 / w; i++)
            begin
                x = lane_sext(get_lane(t, i, w), w);
                if (x < 0) x = (x < -smax) ? smax : -x;
                put_lane(d, i, w, 32'(x));
            end
        end
        else
        begin
            d = {{4{t[79:64]}}, {4{t[15:0]}}};
        end
        if (rd != 5'd0)
        begin
            shadow_regs[rd] = d;
            return {1'b1, d};
        end
        return {1'b0, d};
    endfunction

    // Sends one item, honouring the sender idle rate, and queues its expected result.
    task automatic send_item(input logic [5:0] act, input logic [4:0] rd, input logic [4:0] rs,
                             input logic [4:0] rt, input logic [63:0] lo, input logic [63:0] hi);
        logic [151:0] item;
        item = {3'b000, hi, lo, rt, rs, rd, act};
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= item;
        @(posedge clk);
        while (!s_axis_tready)
        begin
            @(posedge clk);
        end
        result_queue.push_back(predict_simd(item));
    endtask

    task automatic finish_burst();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // Operands biased towards lane extremes so that saturation and compares are hit.
    function automatic logic [63:0] edgy64();
        logic [63:0] v;
        v = rand64();
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(5))
                0: v[i*8 +: 8] = 8'h00;
                1: v[i*8 +: 8] = 8'hff;
                2: v[i*8 +: 8] = 8'h80;
                3: v[i*8 +: 8] = 8'h7f;
                default: ;
            endcase
        end
        return v;
    endfunction

    // Checker: takes result items with a random stall and compares them in order.
    always @(posedge clk)
    begin
        logic [128:0] exp_item;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (result_queue.size() == 0)
                begin
                    $display("%0t unexpected result: expected none, actual %h", $time,
                             m_axis_tdata[128:0]);
                    error_count++;
                end
                else
                begin
                    exp_item = result_queue.pop_front();
                    if (m_axis_tdata[63:0] !== exp_item[63:0])
                    begin
                        $display("%0t result_low: expected %h, actual %h", $time,
                                 exp_item[63:0], m_axis_tdata[63:0]);
                        error_count++;
                    end
                    if (m_axis_tdata[127:64] !== exp_item[127:64])
                    begin
                        $display("%0t result_high: expected %h, actual %h", $time,
                                 exp_item[127:64], m_axis_tdata[127:64]);
                        error_count++;
                    end
                    if (m_axis_tdata[128] !== exp_item[128])
                    begin
                        $display("%0t was_written: expected %b, actual %b", $time,
                                 exp_item[128], m_axis_tdata[128]);
                        error_count++;
                    end
                end
            end
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Loads registers 1-3 and 31 with lane extremes and patterns, then walks all operations.
    task automatic test_directed();
        send_item(psa_pkg::ACT_READ, 5'd0, 5'd0, 5'd0, '0, '0);
        send_item(psa_pkg::ACT_LOAD, 5'd1, 5'd0, 5'd0, '1, '1);
        send_item(psa_pkg::ACT_LOAD, 5'd2, 5'd0, 5'd0, 64'h8000_0000_8000_8080,
                  64'h7fff_ffff_7fff_7f7f);
        send_item(psa_pkg::ACT_LOAD, 5'd3, 5'd0, 5'd0, 64'h0123_4567_89ab_cdef,
                  64'hfedc_ba98_7654_3210);
        send_item(psa_pkg::ACT_LOAD, 5'd31, 5'd0, 5'd0, 64'h8000_8000_8000_8000,
                  64'h8000_0000_8000_0000);
        // Destination zero: value carried, no register changed.
        send_item(psa_pkg::ACT_LOAD, 5'd0, 5'd0, 5'd0, '1, '1);
        send_item(psa_pkg::ACT_READ, 5'd0, 5'd0, 5'd0, '0, '0);
        for (int a = 0; a < psa_pkg::ACT_LOAD; a++)
        begin
            send_item(6'(a), 5'(4 + a % 27), 5'(a % 4), 5'(1 + a % 3), '0, '0);
        end
        send_item(psa_pkg::ACT_ABSH, 5'd5, 5'd0, 5'd31, '0, '0);
        send_item(psa_pkg::ACT_ABSW, 5'd6, 5'd0, 5'd31, '0, '0);
        // Unassigned action codes give an empty result.
        send_item(6'd48, 5'd7, 5'd1, 5'd2, '1, '1);
        send_item(6'd63, 5'd8, 5'd1, 5'd2, '1, '1);
        send_item(psa_pkg::ACT_READ, 5'd0, 5'd7, 5'd0, '0, '0);
        finish_burst();
    endtask

    // Random items with set idle and stall rates; dependent items exercise the forwarding path.
    task automatic test_random(input int count, input int idle, input int stall);
        logic [5:0] act;
        send_idle_pct  = idle;
        recv_stall_pct = stall;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(9))
                0, 1:    act = psa_pkg::ACT_LOAD;
                2:       act = psa_pkg::ACT_READ;
                3:       act = 6'($urandom_range(63, 48));
                default: act = 6'($urandom_range(45));
            endcase
            send_item(act, 5'($urandom_range(31)), 5'($urandom_range(($urandom_range(1)) ? 7 : 31)),
                      5'($urandom_range(($urandom_range(1)) ? 7 : 31)),
                      ($urandom_range(1)) ? edgy64() : rand64(),
                      ($urandom_range(1)) ? edgy64() : rand64());
        end
        finish_burst();
    endtask

    // Sender holds off until the block has drained completely.
    task automatic test_drain_pause();
        while (result_queue.size() != 0)
        begin
            @(posedge clk);
        end
        send_item(psa_pkg::ACT_READ, 5'd0, 5'd3, 5'd0, '0, '0);
        finish_burst();
    endtask

    initial
    begin
        clk            = 1'b0;
        rst_n          = 1'b0;
        s_axis_tvalid  = 1'b0;
        s_axis_tdata   = '0;
        m_axis_tready  = 1'b0;
        error_count    = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int r = 0; r < 32; r++)
        begin
            shadow_regs[r] = '0;
        end
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(600, 0, 0);
        test_drain_pause();
        test_random(400, 87, 0);
        test_random(400, 0, 87);
        test_random(600, 6, 6);
        recv_stall_pct = 0;
        while (result_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (5) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

    initial
    begin
        #2000000;
        $display("tb: failure");
        $finish;
    end

endmodule

// ----- packed_simd_alu_128.f -----
hdl/psa_pkg.sv
hdl/psa_alu.sv
hdl/packed_simd_alu_128.sv
dv/tb_packed_simd_alu_128.sv
